@@ src/nmor_pkg.sv @@
// ============================================================================
// nmor_pkg: shared types, codes and constant functions
// Holds the controller states, the datapath operation codes, the command
// struct between the two, the register indexes and the sine table builders.
// ============================================================================
package nmor_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_COEF_A = 2'd0;
    localparam logic [1:0] CFG_COEF_B = 2'd1;
    localparam logic [1:0] CFG_PERIOD = 2'd2;

    localparam int PERIOD_W = 10;

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [63:0] Q30_ONE    = 64'h4000_0000;

    typedef enum logic [4:0] {
        ST_IDLE, ST_K2, ST_K2_WB, ST_LOOKUP, ST_M_BS, ST_W_Y, ST_M_AY, ST_W_T1,
        ST_M_CK_LO, ST_M_CK_HI, ST_W_T2, ST_M_TT, ST_W_J0, ST_M_P0A, ST_M_P0B,
        ST_W_E0, ST_M_P1A, ST_M_P1B, ST_W_E1, ST_M_P2, ST_W_P2, ST_M_P3, ST_W_P3,
        ST_M_YY, ST_W_W, ST_M_AW_LO, ST_M_AW_HI, ST_W_X, ST_WRAP, ST_FINISH
    } t_state;

    typedef enum logic [4:0] {
        OP_IDLE, OP_LOAD, OP_K2, OP_K2_WB, OP_LOOKUP, OP_M_BS, OP_W_Y, OP_M_AY,
        OP_W_T1, OP_M_CK_LO, OP_M_CK_HI, OP_W_T2, OP_M_TT, OP_W_J0, OP_M_P0A,
        OP_M_P0B, OP_W_E0, OP_M_P1A, OP_M_P1B, OP_W_E1, OP_M_P2, OP_W_P2,
        OP_M_P3, OP_W_P3, OP_M_YY, OP_W_W, OP_M_AW_LO, OP_M_AW_HI, OP_W_X,
        OP_WRAP, OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic half;
    } t_cmd;

    // Unsigned long division by compare and subtract; only used while the
    // constant tables are built.
    function automatic logic [63:0] udiv_const(input logic [63:0] n,
                                               input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= d) begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin(2*pi*t) with t in turns as Q32, result Q30, by a folded Taylor series.
    function automatic logic signed [63:0] sin_turn(input logic [31:0] t);
        logic [63:0] q;
        logic [63:0] theta;
        logic [63:0] th2;
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] dv;
        q = {33'd0, t[30:0]};
        if (q > 64'h4000_0000) begin
            q = 64'h8000_0000 - q;
        end
        theta = (q * TWO_PI_Q30) >> 32;
        th2   = (theta * theta) >> 30;
        r     = Q30_ONE;
        for (int i = 0; i < 6; i++) begin
            case (i)
                0:       dv = 64'd156;
                1:       dv = 64'd110;
                2:       dv = 64'd72;
                3:       dv = 64'd42;
                4:       dv = 64'd20;
                default: dv = 64'd6;
            endcase
            r = Q30_ONE - udiv_const((th2 * r) >> 30, dv);
        end
        s = (theta * r) >> 30;
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        return t[31] ? -$signed(s) : $signed(s);
    endfunction

    // Round a Q30 value half up to frac_bits fraction bits.
    function automatic logic signed [63:0] from_q30(input logic signed [63:0] v,
                                                    input int frac_bits);
        int sh;
        sh = 30 - frac_bits;
        if (sh == 0) begin
            return v;
        end
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

endpackage

@@ src/nmor_ctrl.sv @@
// ============================================================================
// nmor_ctrl: orbit sequencer
// Steps the datapath through one map iteration per pass and counts the passes.
// ============================================================================
module nmor_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_cfg_wr,
    input  logic [1:0]                           i_cfg_index,
    input  logic [nmor_pkg::PERIOD_W-1:0]        i_cfg_data,
    output nmor_pkg::t_cmd                       o_cmd
);

    nmor_pkg::t_state r_state, n_state;
    logic [nmor_pkg::PERIOD_W-1:0] r_period;
    logic [nmor_pkg::PERIOD_W-1:0] r_n;
    logic [nmor_pkg::PERIOD_W-1:0] r_cnt;
    logic                          last;

    assign last = (r_cnt == r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= nmor_pkg::ST_IDLE;
            r_period <= nmor_pkg::PERIOD_W'(1);
            r_n      <= nmor_pkg::PERIOD_W'(1);
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr && i_cfg_index == nmor_pkg::CFG_PERIOD) begin
                r_period <= i_cfg_data;
            end
            if (r_state == nmor_pkg::ST_IDLE && start) begin
                // A period of zero runs as one step.
                r_n   <= (r_period == '0) ? nmor_pkg::PERIOD_W'(1) : r_period;
                r_cnt <= nmor_pkg::PERIOD_W'(1);
            end else if (r_state == nmor_pkg::ST_WRAP && !last) begin
                r_cnt <= r_cnt + nmor_pkg::PERIOD_W'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            nmor_pkg::ST_IDLE:    n_state = start ? nmor_pkg::ST_K2 : nmor_pkg::ST_IDLE;
            nmor_pkg::ST_K2:      n_state = nmor_pkg::ST_K2_WB;
            nmor_pkg::ST_K2_WB:   n_state = nmor_pkg::ST_LOOKUP;
            nmor_pkg::ST_LOOKUP:  n_state = nmor_pkg::ST_M_BS;
            nmor_pkg::ST_M_BS:    n_state = nmor_pkg::ST_W_Y;
            nmor_pkg::ST_W_Y:     n_state = nmor_pkg::ST_M_AY;
            nmor_pkg::ST_M_AY:    n_state = nmor_pkg::ST_W_T1;
            nmor_pkg::ST_W_T1:    n_state = nmor_pkg::ST_M_CK_LO;
            nmor_pkg::ST_M_CK_LO: n_state = nmor_pkg::ST_M_CK_HI;
            nmor_pkg::ST_M_CK_HI: n_state = nmor_pkg::ST_W_T2;
            nmor_pkg::ST_W_T2:    n_state = nmor_pkg::ST_M_TT;
            nmor_pkg::ST_M_TT:    n_state = nmor_pkg::ST_W_J0;
            nmor_pkg::ST_W_J0:    n_state = nmor_pkg::ST_M_P0A;
            nmor_pkg::ST_M_P0A:   n_state = nmor_pkg::ST_M_P0B;
            nmor_pkg::ST_M_P0B:   n_state = nmor_pkg::ST_W_E0;
            nmor_pkg::ST_W_E0:    n_state = nmor_pkg::ST_M_P1A;
            nmor_pkg::ST_M_P1A:   n_state = nmor_pkg::ST_M_P1B;
            nmor_pkg::ST_M_P1B:   n_state = nmor_pkg::ST_W_E1;
            nmor_pkg::ST_W_E1:    n_state = nmor_pkg::ST_M_P2;
            nmor_pkg::ST_M_P2:    n_state = nmor_pkg::ST_W_P2;
            nmor_pkg::ST_W_P2:    n_state = nmor_pkg::ST_M_P3;
            nmor_pkg::ST_M_P3:    n_state = nmor_pkg::ST_W_P3;
            nmor_pkg::ST_W_P3:    n_state = nmor_pkg::ST_M_YY;
            nmor_pkg::ST_M_YY:    n_state = nmor_pkg::ST_W_W;
            nmor_pkg::ST_W_W:     n_state = nmor_pkg::ST_M_AW_LO;
            nmor_pkg::ST_M_AW_LO: n_state = nmor_pkg::ST_M_AW_HI;
            nmor_pkg::ST_M_AW_HI: n_state = nmor_pkg::ST_W_X;
            nmor_pkg::ST_W_X:     n_state = nmor_pkg::ST_WRAP;
            nmor_pkg::ST_WRAP:    n_state = last ? nmor_pkg::ST_FINISH : nmor_pkg::ST_LOOKUP;
            nmor_pkg::ST_FINISH:  n_state = nmor_pkg::ST_IDLE;
            default:              n_state = nmor_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        busy       = (r_state != nmor_pkg::ST_IDLE);
        o_cmd.half = (r_cnt == (r_n >> 1));
        case (r_state)
            nmor_pkg::ST_IDLE:    o_cmd.op = start ? nmor_pkg::OP_LOAD : nmor_pkg::OP_IDLE;
            nmor_pkg::ST_K2:      o_cmd.op = nmor_pkg::OP_K2;
            nmor_pkg::ST_K2_WB:   o_cmd.op = nmor_pkg::OP_K2_WB;
            nmor_pkg::ST_LOOKUP:  o_cmd.op = nmor_pkg::OP_LOOKUP;
            nmor_pkg::ST_M_BS:    o_cmd.op = nmor_pkg::OP_M_BS;
            nmor_pkg::ST_W_Y:     o_cmd.op = nmor_pkg::OP_W_Y;
            nmor_pkg::ST_M_AY:    o_cmd.op = nmor_pkg::OP_M_AY;
            nmor_pkg::ST_W_T1:    o_cmd.op = nmor_pkg::OP_W_T1;
            nmor_pkg::ST_M_CK_LO: o_cmd.op = nmor_pkg::OP_M_CK_LO;
            nmor_pkg::ST_M_CK_HI: o_cmd.op = nmor_pkg::OP_M_CK_HI;
            nmor_pkg::ST_W_T2:    o_cmd.op = nmor_pkg::OP_W_T2;
            nmor_pkg::ST_M_TT:    o_cmd.op = nmor_pkg::OP_M_TT;
            nmor_pkg::ST_W_J0:    o_cmd.op = nmor_pkg::OP_W_J0;
            nmor_pkg::ST_M_P0A:   o_cmd.op = nmor_pkg::OP_M_P0A;
            nmor_pkg::ST_M_P0B:   o_cmd.op = nmor_pkg::OP_M_P0B;
            nmor_pkg::ST_W_E0:    o_cmd.op = nmor_pkg::OP_W_E0;
            nmor_pkg::ST_M_P1A:   o_cmd.op = nmor_pkg::OP_M_P1A;
            nmor_pkg::ST_M_P1B:   o_cmd.op = nmor_pkg::OP_M_P1B;
            nmor_pkg::ST_W_E1:    o_cmd.op = nmor_pkg::OP_W_E1;
            nmor_pkg::ST_M_P2:    o_cmd.op = nmor_pkg::OP_M_P2;
            nmor_pkg::ST_W_P2:    o_cmd.op = nmor_pkg::OP_W_P2;
            nmor_pkg::ST_M_P3:    o_cmd.op = nmor_pkg::OP_M_P3;
            nmor_pkg::ST_W_P3:    o_cmd.op = nmor_pkg::OP_W_P3;
            nmor_pkg::ST_M_YY:    o_cmd.op = nmor_pkg::OP_M_YY;
            nmor_pkg::ST_W_W:     o_cmd.op = nmor_pkg::OP_W_W;
            nmor_pkg::ST_M_AW_LO: o_cmd.op = nmor_pkg::OP_M_AW_LO;
            nmor_pkg::ST_M_AW_HI: o_cmd.op = nmor_pkg::OP_M_AW_HI;
            nmor_pkg::ST_W_X:     o_cmd.op = nmor_pkg::OP_W_X;
            nmor_pkg::ST_WRAP:    o_cmd.op = nmor_pkg::OP_WRAP;
            nmor_pkg::ST_FINISH:  o_cmd.op = nmor_pkg::OP_FINISH;
            default:              o_cmd.op = nmor_pkg::OP_IDLE;
        endcase
    end

    // The step counter stays within the orbit length while an orbit runs.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != nmor_pkg::ST_IDLE) |-> (r_cnt != '0 && r_cnt <= r_n))
        else $error("step counter out of range");

    // An accepted start leaves idle at once.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && r_state == nmor_pkg::ST_IDLE) |=> (r_state == nmor_pkg::ST_K2))
        else $error("start not taken");

endmodule

@@ src/nmor_dpath.sv @@
// ============================================================================
// nmor_dpath: orbit datapath
// One shared multiplier with an accumulator, the sine and cosine tables, the
// point, Jacobian product and winding registers, and the result registers.
// ============================================================================
module nmor_dpath #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int FRACTION_BITS    = 28
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nmor_pkg::t_cmd      i_cmd,
    input  logic                i_cfg_wr,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic signed [31:0]  i_start_x,
    input  logic signed [31:0]  i_start_y,
    output logic signed [31:0]  o_end_x,
    output logic signed [31:0]  o_end_y,
    output logic signed [15:0]  o_winding,
    output logic signed [31:0]  o_half_y,
    output logic signed [31:0]  o_residue_value,
    output logic                o_overflow,
    output logic                o_done
);

    localparam int F    = FRACTION_BITS;
    localparam int IB   = $clog2(SINE_TABLE_DEPTH);
    localparam int AWID = 34;
    localparam int MW0  = (F + 1 > 66 - 2 * F) ? F + 1 : 66 - 2 * F;
    localparam int MW   = (MW0 > 32) ? MW0 : 32;
    localparam int PW   = AWID + MW;
    localparam int AW   = PW + 1;
    localparam int SW   = AW + 3;
    localparam int KW   = 65 - F;
    localparam int WW   = 66 - F;
    localparam int XW   = AW + 1;

    localparam logic signed [63:0] TWO_PI_Q = nmor_pkg::from_q30($signed(nmor_pkg::TWO_PI_Q30), F);
    localparam longint HI_L = ((longint'(11) << F) + 10) / 20;
    localparam longint LO_L = HI_L - (longint'(1) << F);
    localparam logic signed [XW-1:0] HI_X   = XW'(HI_L);
    localparam logic signed [XW-1:0] LO_X   = XW'(LO_L);
    localparam logic signed [XW-1:0] MASK_X = XW'((longint'(1) << F) - 1);
    localparam logic signed [SW-1:0] Q_SW   = SW'(longint'(1) << F);
    localparam logic signed [SW-1:0] S_MAX  = SW'(64'sh7FFF_FFFF);
    localparam logic signed [SW-1:0] S_MIN  = SW'(-64'sh8000_0000);

    typedef logic signed [31:0] t_rom [SINE_TABLE_DEPTH];
    typedef enum logic [1:0] {MM_NONE, MM_LOAD, MM_ADD, MM_ADD_RAW} t_mmode;

    function automatic t_rom build_rom(input logic cos_sel);
        t_rom                rom;
        logic [63:0]         tw;
        logic [31:0]         t;
        logic signed [63:0]  v;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            tw     = 64'(k) << (32 - IB);
            t      = tw[31:0] + (cos_sel ? 32'h4000_0000 : 32'h0);
            v      = nmor_pkg::from_q30(nmor_pkg::sin_turn(t), F);
            rom[k] = v[31:0];
        end
        return rom;
    endfunction

    function automatic logic [32:0] sat32(input logic signed [SW-1:0] v);
        logic [32:0] r;
        if (v > S_MAX) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < S_MIN) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    localparam t_rom SIN_ROM = build_rom(1'b0);
    localparam t_rom COS_ROM = build_rom(1'b1);

    logic signed [31:0]   r_coef_a, r_coef_b;
    logic signed [KW-1:0] r_k2;
    logic signed [31:0]   r_sv, r_cv, r_px, r_py, r_t1, r_t2, r_j0, r_e0, r_e1;
    logic signed [31:0]   r_p0, r_p1, r_p2, r_p3, r_half;
    logic signed [WW-1:0] r_w;
    logic signed [XW-1:0] r_xn;
    logic signed [AW-1:0] r_acc;
    logic [15:0]          r_wc;
    logic                 r_ovf;
    logic                 r_done;

    logic signed [AWID-1:0] mul_a;
    logic signed [MW-1:0]   mul_b;
    logic signed [PW-1:0]   prod;
    logic signed [AW-1:0]   prod_sh, prod_raw;
    t_mmode                 mmode;
    logic signed [SW-1:0]   acc_sw, sat_in, res_sw;
    logic [32:0]            sat_res;
    logic                   sat_flags;
    logic signed [XW-1:0]   x_up, x_dn, d_up, d_dn;
    logic [IB-1:0]          idx;

    assign idx = r_px[F-1 -: IB];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mmode = MM_NONE;
        case (i_cmd.op)
            nmor_pkg::OP_K2: begin
                mul_a = TWO_PI_Q[AWID-1:0]; mul_b = MW'(r_coef_b); mmode = MM_LOAD;
            end
            nmor_pkg::OP_M_BS: begin
                mul_a = AWID'(r_coef_b); mul_b = MW'(r_sv); mmode = MM_LOAD;
            end
            nmor_pkg::OP_M_AY: begin
                mul_a = AWID'(r_coef_a); mul_b = MW'(r_py); mmode = MM_LOAD;
            end
            nmor_pkg::OP_M_CK_LO: begin
                mul_a = AWID'(r_cv); mul_b = MW'({1'b0, r_k2[F-1:0]}); mmode = MM_LOAD;
            end
            nmor_pkg::OP_M_CK_HI: begin
                mul_a = AWID'(r_cv); mul_b = MW'(r_k2 >>> F); mmode = MM_ADD_RAW;
            end
            nmor_pkg::OP_M_TT: begin
                mul_a = AWID'(r_t1); mul_b = MW'(r_t2); mmode = MM_LOAD;
            end
            nmor_pkg::OP_M_P0A: begin
                mul_a = AWID'(r_j0); mul_b = MW'(r_p0); mmode = MM_LOAD;
            end
            nmor_pkg::OP_M_P0B: begin
                mul_a = AWID'(r_t1); mul_b = MW'(r_p2); mmode = MM_ADD;
            end
            nmor_pkg::OP_M_P1A: begin
                mul_a = AWID'(r_j0); mul_b = MW'(r_p1); mmode = MM_LOAD;
            end
            nmor_pkg::OP_M_P1B: begin
                mul_a = AWID'(r_t1); mul_b = MW'(r_p3); mmode = MM_ADD;
            end
            nmor_pkg::OP_M_P2: begin
                mul_a = AWID'(r_t2); mul_b = MW'(r_p0); mmode = MM_LOAD;
            end
            nmor_pkg::OP_M_P3: begin
                mul_a = AWID'(r_t2); mul_b = MW'(r_p1); mmode = MM_LOAD;
            end
            nmor_pkg::OP_M_YY: begin
                mul_a = AWID'(r_py); mul_b = MW'(r_py); mmode = MM_LOAD;
            end
            nmor_pkg::OP_M_AW_LO: begin
                mul_a = AWID'(r_coef_a); mul_b = MW'({1'b0, r_w[F-1:0]}); mmode = MM_LOAD;
            end
            nmor_pkg::OP_M_AW_HI: begin
                mul_a = AWID'(r_coef_a); mul_b = MW'(r_w >>> F); mmode = MM_ADD_RAW;
            end
            default: begin
                mmode = MM_NONE;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_sh  = AW'(prod >>> F);
    assign prod_raw = AW'(prod);
    assign acc_sw   = SW'(r_acc);
    assign res_sw   = ((Q_SW <<< 1) - SW'(r_p0) - SW'(r_p3)) >>> 2;

    always_comb begin
        case (i_cmd.op)
            nmor_pkg::OP_W_Y:   sat_in = SW'(r_py) - acc_sw;
            nmor_pkg::OP_W_T1:  sat_in = -(acc_sw <<< 1);
            nmor_pkg::OP_W_T2:  sat_in = -acc_sw;
            nmor_pkg::OP_W_J0:  sat_in = Q_SW + acc_sw;
            nmor_pkg::OP_W_P2:  sat_in = acc_sw + SW'(r_p2);
            nmor_pkg::OP_W_P3:  sat_in = acc_sw + SW'(r_p3);
            nmor_pkg::OP_FINISH: sat_in = res_sw;
            default:            sat_in = acc_sw;
        endcase
        sat_res   = sat32(sat_in);
        // Saturating y after the sine step is silent; the rest raise the flag.
        sat_flags = sat_res[32] &&
                    (i_cmd.op == nmor_pkg::OP_W_T1 || i_cmd.op == nmor_pkg::OP_W_T2 ||
                     i_cmd.op == nmor_pkg::OP_W_J0 || i_cmd.op == nmor_pkg::OP_W_E0 ||
                     i_cmd.op == nmor_pkg::OP_W_E1 || i_cmd.op == nmor_pkg::OP_W_P2 ||
                     i_cmd.op == nmor_pkg::OP_W_P3 || i_cmd.op == nmor_pkg::OP_FINISH);
    end

    // Wrap x back into the window: from above into (LO, HI], from below into [LO, HI).
    assign x_up = LO_X + XW'(1) + ((r_xn - LO_X - XW'(1)) & MASK_X);
    assign x_dn = LO_X + ((r_xn - LO_X) & MASK_X);
    assign d_up = r_xn - x_up;
    assign d_dn = x_dn - r_xn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= '0;
            r_coef_b <= '0;
            r_done   <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            if (i_cfg_wr && i_cfg_index == nmor_pkg::CFG_COEF_A) begin
                r_coef_a <= i_cfg_data;
            end
            if (i_cfg_wr && i_cfg_index == nmor_pkg::CFG_COEF_B) begin
                r_coef_b <= i_cfg_data;
            end
            r_done <= (i_cmd.op == nmor_pkg::OP_FINISH);
            if (i_cmd.op == nmor_pkg::OP_LOAD) begin
                r_ovf <= 1'b0;
            end else if (sat_flags) begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (mmode)
            MM_LOAD:    r_acc <= prod_sh;
            MM_ADD:     r_acc <= r_acc + prod_sh;
            MM_ADD_RAW: r_acc <= r_acc + prod_raw;
            default:    r_acc <= r_acc;
        endcase
        case (i_cmd.op)
            nmor_pkg::OP_LOAD: begin
                r_px   <= i_start_x;
                r_py   <= i_start_y;
                r_wc   <= '0;
                r_p0   <= Q_SW[31:0];
                r_p1   <= '0;
                r_p2   <= '0;
                r_p3   <= Q_SW[31:0];
                r_half <= '0;
            end
            nmor_pkg::OP_K2_WB:  r_k2 <= r_acc[KW-1:0];
            nmor_pkg::OP_LOOKUP: begin
                r_sv <= SIN_ROM[idx];
                r_cv <= COS_ROM[idx];
            end
            nmor_pkg::OP_W_Y:  r_py <= sat_res[31:0];
            nmor_pkg::OP_W_T1: r_t1 <= sat_res[31:0];
            nmor_pkg::OP_W_T2: r_t2 <= sat_res[31:0];
            nmor_pkg::OP_W_J0: r_j0 <= sat_res[31:0];
            nmor_pkg::OP_W_E0: r_e0 <= sat_res[31:0];
            nmor_pkg::OP_W_E1: r_e1 <= sat_res[31:0];
            nmor_pkg::OP_W_P2: begin
                r_p2 <= sat_res[31:0];
                r_p0 <= r_e0;
            end
            nmor_pkg::OP_W_P3: begin
                r_p3 <= sat_res[31:0];
                r_p1 <= r_e1;
            end
            nmor_pkg::OP_W_W:  r_w  <= WW'(Q_SW - acc_sw);
            nmor_pkg::OP_W_X:  r_xn <= XW'(r_px) + XW'(r_acc);
            nmor_pkg::OP_WRAP: begin
                if (r_xn > HI_X) begin
                    r_px <= x_up[31:0];
                    r_wc <= r_wc + d_up[F+15:F];
                end else if (r_xn < LO_X) begin
                    r_px <= x_dn[31:0];
                    r_wc <= r_wc - d_dn[F+15:F];
                end else begin
                    r_px <= r_xn[31:0];
                end
                if (i_cmd.half) begin
                    r_half <= r_py;
                end
            end
            nmor_pkg::OP_FINISH: begin
                o_end_x         <= r_px;
                o_end_y         <= r_py;
                o_winding       <= r_wc;
                o_half_y        <= r_half;
                o_residue_value <= sat_res[31:0];
                o_overflow      <= r_ovf | sat_res[32];
            end
            default: begin
                r_px <= r_px;
            end
        endcase
    end

    assign o_done = r_done;

    // The result strobe lasts a single cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // After a wrap the point lies inside the window.
    a_wrap_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == nmor_pkg::OP_WRAP) |=> (XW'(r_px) >= LO_X && XW'(r_px) <= HI_X))
        else $error("x outside the wrap window");

endmodule

@@ src/nontwist_map_orbit_residue.sv @@
// ============================================================================
// nontwist_map_orbit_residue: nontwist map orbit with Greene residue
// Iterates the standard nontwist map from a start point and returns the end
// point, winding number, mid-orbit y and the residue of the Jacobian product.
// ============================================================================
// An orbit is launched by raising start while busy is low; the block then
// runs period map steps (a period of zero runs one) and presents the result
// for exactly one cycle with o_done high. The receiver cannot stall, so it
// must take the beat in that cycle; the result ports hold their values until
// the next orbit finishes. Every map step runs the single shared multiplier
// over the sine term, the Jacobian entries, the four product entries and
// the x update one after another. The next start is taken in the cycle of
// the o_done beat. The configuration port is always ready; write it only
// while busy is low. All values are signed fixed point with FRACTION_BITS
// fraction bits; sine and cosine come from constant tables of
// SINE_TABLE_DEPTH entries, which must be a power of two.
// ============================================================================
module nontwist_map_orbit_residue #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int FRACTION_BITS    = 28
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    output logic signed [31:0] o_end_x,
    output logic signed [31:0] o_end_y,
    output logic signed [15:0] o_winding,
    output logic signed [31:0] o_half_y,
    output logic signed [31:0] o_residue_value,
    output logic               o_overflow,
    output logic               o_done
);

    nmor_pkg::t_cmd cmd;
    logic           cfg_wr;

    // Configuration writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    nmor_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data[nmor_pkg::PERIOD_W-1:0]),
        .o_cmd       (cmd)
    );

    nmor_dpath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .FRACTION_BITS    (FRACTION_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_wr        (cfg_wr),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .o_end_x         (o_end_x),
        .o_end_y         (o_end_y),
        .o_winding       (o_winding),
        .o_half_y        (o_half_y),
        .o_residue_value (o_residue_value),
        .o_overflow      (o_overflow),
        .o_done          (o_done)
    );

endmodule
